// File: hdl/b64e_pkg.sv
// Package for the line-wrapped Base64 encoder: widths, character codes,
// the Base64 symbol map and the structs shared between the encoder's modules.
// No dependencies.
`default_nettype none

package b64e_pkg;

  localparam int DATA_W         = 8;
  localparam int CHAR_W         = 7;
  localparam int GRP_W          = 8;
  localparam int CHARS_PER_LINE = 76;
  localparam int GROUPS_PER_LINE_RAW = CHARS_PER_LINE / 4;
  localparam int GROUPS_PER_LINE = (GROUPS_PER_LINE_RAW == 0) ? 1 : GROUPS_PER_LINE_RAW;

  localparam logic [CHAR_W-1:0] CHAR_PAD = 7'd61;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 7'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 7'd10;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
    logic              text_end;
  } char_t;

  typedef struct packed {
    char_t [3:0] chars;
    logic  [1:0] last_idx;
  } burst_t;

  function automatic logic [CHAR_W-1:0] b64_sym(input logic [5:0] v);
    logic [CHAR_W-1:0] w;
    w = {1'b0, v};
    if (v < 6'd26) begin
      return w + 7'd65;
    end else if (v < 6'd52) begin
      return w + 7'd71;
    end else if (v < 6'd62) begin
      return w - 7'd4;
    end else if (v == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/b64e_if.sv
// Stream interfaces for the Base64 encoder: message bytes in, characters out.
// Depends on b64e_pkg for field widths.
`default_nettype none

interface b64e_in_if;
  logic                        valid;
  logic                        ready;
  logic [b64e_pkg::DATA_W-1:0] data_byte;
  logic                        message_end;
  modport source (output valid, data_byte, message_end, input ready);
  modport sink (input valid, data_byte, message_end, output ready);
endinterface

interface b64e_out_if;
  logic                        valid;
  logic                        ready;
  logic [b64e_pkg::CHAR_W-1:0] out_char;
  logic                        run_last;
  logic                        text_end;
  modport source (output valid, out_char, run_last, text_end, input ready);
  modport sink (input valid, out_char, run_last, text_end, output ready);
endinterface

`default_nettype wire

// File: hdl/b64e_encode.sv
// Input register and encode logic: turns one registered byte into a burst of
// one to four characters and keeps group phase, held bits and line count.
// Depends on b64e_pkg and b64e_in_if.
`default_nettype none

module b64e_encode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            line_wrap,
  b64e_in_if.sink              msg,
  output b64e_pkg::burst_t     burst,
  output logic                 burst_valid,
  input  wire logic            burst_take
);

  logic                         s1_valid;
  logic [b64e_pkg::DATA_W-1:0]  s1_byte;
  logic                         s1_end;

  logic [1:0]                   phase, phase_next;
  logic [3:0]                   held, held_next;
  logic [b64e_pkg::GRP_W-1:0]   groups, groups_next;
  logic [b64e_pkg::GRP_W:0]     groups_inc;
  logic                         line_full;
  logic [1:0]                   last_idx;
  b64e_pkg::char_t [3:0]        chars;

  assign msg.ready   = !s1_valid || burst_take;
  assign burst_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      s1_byte <= msg.data_byte;
      s1_end  <= msg.message_end;
    end
  end

  always_comb begin
    groups_inc = {1'b0, groups} + 9'd1;
    line_full  = groups_inc >= (b64e_pkg::GRP_W+1)'(b64e_pkg::GROUPS_PER_LINE);
    for (int i = 0; i < 4; i++) begin
      chars[i].out_char = b64e_pkg::CHAR_PAD;
      chars[i].run_last = 1'b0;
      chars[i].text_end = 1'b0;
    end
    phase_next  = phase;
    held_next   = held;
    groups_next = groups;
    last_idx    = 2'd0;
    case (phase)
      b64e_pkg::PHASE_SECOND: begin
        chars[0].out_char = b64e_pkg::b64_sym({held[1:0], s1_byte[7:4]});
        held_next  = s1_byte[3:0];
        phase_next = b64e_pkg::PHASE_THIRD;
        if (s1_end) begin
          chars[1].out_char = b64e_pkg::b64_sym({s1_byte[3:0], 2'b00});
          last_idx = 2'd2;
        end
      end
      b64e_pkg::PHASE_THIRD: begin
        chars[0].out_char = b64e_pkg::b64_sym({held, s1_byte[7:6]});
        chars[1].out_char = b64e_pkg::b64_sym(s1_byte[5:0]);
        held_next  = 4'd0;
        phase_next = b64e_pkg::PHASE_FIRST;
        last_idx   = 2'd1;
        if (line_full) begin
          groups_next = '0;
          if (line_wrap) begin
            chars[2].out_char = b64e_pkg::CHAR_CR;
            chars[3].out_char = b64e_pkg::CHAR_LF;
            last_idx = 2'd3;
          end
        end else begin
          groups_next = groups_inc[b64e_pkg::GRP_W-1:0];
        end
      end
      default: begin
        chars[0].out_char = b64e_pkg::b64_sym(s1_byte[7:2]);
        held_next  = {2'b00, s1_byte[1:0]};
        phase_next = b64e_pkg::PHASE_SECOND;
        if (s1_end) begin
          chars[1].out_char = b64e_pkg::b64_sym({s1_byte[1:0], 4'b0000});
          last_idx = 2'd3;
        end
      end
    endcase
    chars[last_idx].run_last = 1'b1;
    chars[last_idx].text_end = s1_end;
    if (s1_end) begin
      phase_next  = b64e_pkg::PHASE_FIRST;
      held_next   = 4'd0;
      groups_next = '0;
    end
  end

  assign burst.chars    = chars;
  assign burst.last_idx = last_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= b64e_pkg::PHASE_FIRST;
      held   <= 4'd0;
      groups <= '0;
    end else if (s1_valid && burst_take) begin
      phase  <= phase_next;
      held   <= held_next;
      groups <= groups_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/b64e_char_buf.sv
// Result register: holds one burst of characters and sends them one beat per
// cycle while text is ready, loading the next burst as the last character leaves.
// Depends on b64e_pkg and b64e_out_if.
`default_nettype none

module b64e_char_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire b64e_pkg::burst_t  burst,
  input  wire logic              burst_valid,
  output logic                   burst_take,
  b64e_out_if.source             text
);

  logic                    buf_valid;
  b64e_pkg::char_t [3:0]   chars;
  logic [1:0]              idx;
  logic [1:0]              last_idx;
  logic                    beat;

  assign beat       = buf_valid && text.ready;
  assign burst_take = !buf_valid || (beat && (idx == last_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (burst_take) begin
      buf_valid <= burst_valid;
      idx       <= 2'd0;
    end else if (beat) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_take && burst_valid) begin
      chars    <= burst.chars;
      last_idx <= burst.last_idx;
    end
  end

  assign text.valid    = buf_valid;
  assign text.out_char = chars[idx].out_char;
  assign text.run_last = chars[idx].run_last;
  assign text.text_end = chars[idx].text_end;

endmodule

`default_nettype wire

// File: hdl/base64_line_wrapped_encoder_top.sv
// Top level of the line-wrapped Base64 encoder: line_wrap register, encoder
// stage and character buffer. Depends on b64e_pkg, b64e_if, b64e_encode and
// b64e_char_buf.
//
//   channel  dir  beat                               handshake
//   msg      in   data_byte[7:0], message_end        valid/ready
//   text     out  out_char[6:0], run_last, text_end  valid/ready
//   cfg      in   cfg_data (line_wrap)               cfg_write, no ready
//
// One character leaves per cycle while text is ready; a byte yields one to four
// characters. The first character passes the input register and the character
// buffer before it is offered. The character buffer's one-beat-per-cycle output
// sets the rate. Synchronous reset clears state and line_wrap.
// A stall on text holds the current character; msg stays ready while the
// input register is free or the buffer is taking its next burst.
`default_nettype none

module base64_line_wrapped_encoder_top (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write,
  input  wire logic  cfg_data,
  b64e_in_if.sink    msg,
  b64e_out_if.source text
);

  logic              line_wrap;
  b64e_pkg::burst_t  burst;
  logic              burst_valid;
  logic              burst_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_wrap <= 1'b0;
    end else if (cfg_write) begin
      line_wrap <= cfg_data;
    end
  end

  b64e_encode u_encode (
    .clk         (clk),
    .rst         (rst),
    .line_wrap   (line_wrap),
    .msg         (msg),
    .burst       (burst),
    .burst_valid (burst_valid),
    .burst_take  (burst_take)
  );

  b64e_char_buf u_char_buf (
    .clk         (clk),
    .rst         (rst),
    .burst       (burst),
    .burst_valid (burst_valid),
    .burst_take  (burst_take),
    .text        (text)
  );

endmodule

`default_nettype wire

// File: hdl/b64e_checker.sv
// Port checker for the Base64 encoder top level, attached with bind.
// Depends on b64e_pkg for widths and character codes.
`default_nettype none

module b64e_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        msg_ready,
  input wire logic                        text_valid,
  input wire logic                        text_ready,
  input wire logic [b64e_pkg::CHAR_W-1:0] text_char,
  input wire logic                        text_run_last,
  input wire logic                        text_end
);

  logic prev_cr;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cr <= 1'b0;
    end else if (text_valid && text_ready) begin
      prev_cr <= (text_char == b64e_pkg::CHAR_CR);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=> text_valid && $stable(text_char)
      && $stable(text_run_last) && $stable(text_end))
    else $error("text beat changed while stalled");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_end |-> text_run_last)
    else $error("text_end without run_last");

  a_cr_then_lf: assert property (@(posedge clk) disable iff (rst)
    text_valid && prev_cr |-> text_char == b64e_pkg::CHAR_LF)
    else $error("CR not followed by LF");

  a_input_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !msg_ready |-> text_valid)
    else $error("input stalled with no character pending");

endmodule

bind base64_line_wrapped_encoder_top b64e_checker u_b64e_checker (
  .clk           (clk),
  .rst           (rst),
  .msg_ready     (msg.ready),
  .text_valid    (text.valid),
  .text_ready    (text.ready),
  .text_char     (text.out_char),
  .text_run_last (text.run_last),
  .text_end      (text.text_end)
);

`default_nettype wire

// File: tb/base64_line_wrapped_encoder_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for base64_line_wrapped_encoder_top: feeds message bytes,
// predicts the Base64 character stream with line wrapping, and checks every beat.
// Depends on b64e_pkg and the b64e_in_if / b64e_out_if interfaces.

module base64_line_wrapped_encoder_top_test;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 40;
  localparam bit [8*64-1:0] B64_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [b64e_pkg::DATA_W-1:0] data;
    logic                        fin;
  } msg_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic cfg_data;

  b64e_in_if  msg_bus ();
  b64e_out_if text_bus ();

  base64_line_wrapped_encoder_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .msg       (msg_bus),
    .text      (text_bus)
  );

  always #4 clk = ~clk;

  msg_byte_t         byte_queue[$];
  b64e_pkg::char_t   expected_chars[$];

  logic [1:0]  enc_phase = b64e_pkg::PHASE_FIRST;
  logic [3:0]  enc_held = 4'd0;
  logic [7:0]  enc_groups = 8'd0;
  logic        wrap_shadow = 1'b0;

  int          idle_pct = 30;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          bytes_in = 0;
  int          messages_done = 0;
  int          chars_checked = 0;
  int          line_breaks = 0;
  b64e_pkg::char_t got;
  b64e_pkg::char_t want;

  function automatic logic [b64e_pkg::CHAR_W-1:0] b64_char(input logic [5:0] v);
    return B64_CHARS[8*(63-v) +: b64e_pkg::CHAR_W];
  endfunction

  // advance the encoder state by one byte and queue the characters it yields
  task automatic encode_byte(input logic [b64e_pkg::DATA_W-1:0] b, input logic fin);
    logic [b64e_pkg::CHAR_W-1:0] burst[$];
    b64e_pkg::char_t c;
    case (enc_phase)
      b64e_pkg::PHASE_SECOND: begin
        burst.push_back(b64_char({enc_held[1:0], b[7:4]}));
        enc_held = b[3:0];
        enc_phase = b64e_pkg::PHASE_THIRD;
        if (fin) begin
          burst.push_back(b64_char({enc_held, 2'b00}));
          burst.push_back(b64e_pkg::CHAR_PAD);
        end
      end
      b64e_pkg::PHASE_THIRD: begin
        burst.push_back(b64_char({enc_held, b[7:6]}));
        burst.push_back(b64_char(b[5:0]));
        enc_held = 4'd0;
        enc_phase = b64e_pkg::PHASE_FIRST;
        enc_groups = enc_groups + 8'd1;
        if (enc_groups >= b64e_pkg::GROUPS_PER_LINE) begin
          enc_groups = 8'd0;
          if (wrap_shadow) begin
            burst.push_back(b64e_pkg::CHAR_CR);
            burst.push_back(b64e_pkg::CHAR_LF);
            line_breaks++;
          end
        end
      end
      default: begin
        burst.push_back(b64_char(b[7:2]));
        enc_held = {2'b00, b[1:0]};
        enc_phase = b64e_pkg::PHASE_SECOND;
        if (fin) begin
          burst.push_back(b64_char({enc_held[1:0], 4'b0000}));
          burst.push_back(b64e_pkg::CHAR_PAD);
          burst.push_back(b64e_pkg::CHAR_PAD);
        end
      end
    endcase
    foreach (burst[k]) begin
      c.out_char = burst[k];
      c.run_last = (k == burst.size() - 1);
      c.text_end = fin && (k == burst.size() - 1);
      expected_chars.push_back(c);
    end
    if (fin) begin
      enc_phase = b64e_pkg::PHASE_FIRST;
      enc_held = 4'd0;
      enc_groups = 8'd0;
      messages_done++;
    end
  endtask

  // sender: hold the beat under backpressure, advance on acceptance
  always @(posedge clk) begin
    if (rst) begin
      msg_bus.valid <= 1'b0;
      msg_bus.data_byte <= '0;
      msg_bus.message_end <= 1'b0;
    end else begin
      if (msg_bus.valid && msg_bus.ready) begin
        encode_byte(byte_queue[0].data, byte_queue[0].fin);
        byte_queue.pop_front();
        bytes_in++;
      end
      if (!msg_bus.valid || msg_bus.ready) begin
        if (byte_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          msg_bus.valid <= 1'b1;
          msg_bus.data_byte <= byte_queue[0].data;
          msg_bus.message_end <= byte_queue[0].fin;
        end else begin
          msg_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each character beat against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      text_bus.ready <= 1'b0;
    end else begin
      if (text_bus.valid && text_bus.ready) begin
        got.out_char = text_bus.out_char;
        got.run_last = text_bus.run_last;
        got.text_end = text_bus.text_end;
        if (expected_chars.size() == 0) begin
          $error("unexpected character beat: out_char %0d", got.out_char);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (got.out_char !== want.out_char) begin
            $error("out_char: expected %0d, got %0d", want.out_char, got.out_char);
            mismatches++;
          end
          if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
            mismatches++;
          end
          if (got.text_end !== want.text_end) begin
            $error("text_end: expected %0d, got %0d", want.text_end, got.text_end);
            mismatches++;
          end
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen <= hold_reqs;
        hold_left <= HOLD_CYCLES;
        text_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        text_bus.ready <= 1'b0;
      end else begin
        text_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  task automatic push_byte(input logic [b64e_pkg::DATA_W-1:0] b, input logic fin);
    msg_byte_t m;
    m.data = b;
    m.fin = fin;
    byte_queue.push_back(m);
  endtask

  task automatic push_message(input int len, input bit finish);
    for (int i = 0; i < len; i++) begin
      push_byte((b64e_pkg::DATA_W)'($urandom_range(0, 255)), finish && (i == len - 1));
    end
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_wrap(input logic v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    wrap_shadow = v;
  endtask

  initial begin
    #1_600_000;
    $display("base64_line_wrapped_encoder_top verification failed");
    $finish;
  end

  initial begin
    int phase_items;
    int len;
    int pick;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    msg_bus.valid = 1'b0;
    msg_bus.data_byte = '0;
    msg_bus.message_end = 1'b0;
    text_bus.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: pad cases, full group, extreme symbols, wrap on
    write_wrap(1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFB, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBE, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    drain();

    // directed, wrap off; leave a message open across the next write
    write_wrap(1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h3C, 1'b0);
    push_byte(8'hC3, 1'b0);
    drain();

    // random messages; pause for a full drain between settings
    for (int p = 0; p < 6; p++) begin
      write_wrap(p % 2 == 0);
      idle_pct = (p == 1) ? 0 : 30;
      if (p == 3) begin
        hold_reqs <= hold_reqs + 1;
      end
      phase_items = 0;
      if (p == 0) begin
        push_message(b64e_pkg::GROUPS_PER_LINE * 3, 1'b1);
        phase_items += b64e_pkg::GROUPS_PER_LINE * 3;
      end
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          len = $urandom_range(1, 6);
        end else if (pick < 8) begin
          len = $urandom_range(7, 60);
        end else if (pick == 8) begin
          len = b64e_pkg::GROUPS_PER_LINE * 3 * $urandom_range(1, 2);
        end else begin
          len = $urandom_range(b64e_pkg::GROUPS_PER_LINE * 3 - 2,
                               b64e_pkg::GROUPS_PER_LINE * 3 + 3);
        end
        push_message(len, 1'b1);
        phase_items += len;
      end
      if (p != 5 && $urandom_range(0, 1) == 1) begin
        push_message($urandom_range(1, 5), 1'b0);
      end
      drain();
    end

    idle_pct = 30;
    drain();
    $display("covered %0d bytes in %0d messages, %0d characters checked,",
             bytes_in, messages_done, chars_checked);
    $display("%0d line breaks, wrap toggled mid-message, one long receiver hold",
             line_breaks);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("base64_line_wrapped_encoder_top verification clean");
    end else begin
      $display("base64_line_wrapped_encoder_top verification failed");
    end
    $finish;
  end

endmodule
